// File: src/fpga_passive_serial_loader_assert.svh
// assertion macros for the passive serial loader
`ifndef FPGA_PASSIVE_SERIAL_LOADER_ASSERT_SVH
`define FPGA_PASSIVE_SERIAL_LOADER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge out of reset
`define FPL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition in the cycle after a trigger
`define FPL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define FPL_ASSERT_ALWAYS(lbl, cond, msg)
`define FPL_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: src/fpl_pkg.sv
package fpl_pkg;

  localparam int CountW = 21;
  localparam int WaitW  = 8;

  localparam logic [CountW-1:0] ByteCountRst    = '0;
  localparam logic [WaitW-1:0]  HighWaitRst     = 8'd50;
  localparam logic [WaitW-1:0]  LowPulseWaitRst = 8'd60;
  localparam logic [WaitW-1:0]  RiseWaitRst     = 8'd30;
  localparam logic [WaitW-1:0]  InitWaitRst     = 8'd40;

  // pin latch bits
  localparam logic [2:0] PinConfig = 3'b100;
  localparam logic [2:0] PinClock  = 3'b010;
  localparam logic [2:0] PinData   = 3'b001;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HIGH = 3'd1,
    PH_LOW  = 3'd2,
    PH_RISE = 3'd3,
    PH_DATA = 3'd4,
    PH_INIT = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_CONF_ERR = 3'd2,
    ST_LOAD_ERR = 3'd3,
    ST_INIT_ERR = 3'd4,
    ST_REJECT   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_BYTE_COUNT = 3'd0,
    REG_HIGH_WAIT  = 3'd1,
    REG_LOW_WAIT   = 3'd2,
    REG_RISE_WAIT  = 3'd3,
    REG_INIT_WAIT  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic [WaitW-1:0]  high_wait;
    logic [WaitW-1:0]  low_pulse_wait;
    logic [WaitW-1:0]  rise_wait;
    logic [WaitW-1:0]  init_wait;
  } cfg_t;

  typedef struct packed {
    logic       done_pin;
    logic       stat_pin;
    logic [7:0] data_byte;
    cmd_t       cmd;
  } item_t;

  typedef struct packed {
    phase_t            phase;
    logic [WaitW-1:0]  wait_counter;
    logic [CountW-1:0] bytes_left;
    logic [2:0]        pins;
  } state_t;

  // what one item hands to the output stage
  typedef struct packed {
    logic       multi;     // sixteen beats of a data byte
    logic [7:0] byte_val;
    logic [2:0] pins;      // pins of a single-beat result
    status_t    status;    // status of the final beat
  } burst_t;

endpackage

// File: src/fpga_passive_serial_loader.sv
// passive serial configuration loader
// s_* channel takes commands: s_tuser is the command (tick, start, data byte),
// s_tdata carries the byte and the sampled status / done pins of the target.
// m_* channel gives pin levels and a status code, one transfer per pin update;
// m_tlast marks the final transfer caused by an input item.
// cfg_* channel writes the byte count and wait registers; always ready.
// an item waits in the input register, is evaluated combinationally in a single
// pass and its first result is loaded into the output register as it leaves.
// throughput: one item per cycle for ticks, starts and rejected items while the
// output register can take their results; a data byte is sent as a serial burst
// (two pin updates per bit); an item with results waits until the last update is taken.
// ticks in idle or data phase give no transfer and leave without waiting.
// reset clears the phase, counters and pin latch to low and loads the wait
// registers with their defaults; both channels come up empty.
// when the receiver stalls, the output register holds and backpressure
// reaches s_tready once the input register also holds an item with results.
module fpga_passive_serial_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], stat_pin, done_pin, zero fill
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // config_pin, clock_pin, data_pin, status_code[2:0], zero fill
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  `include "fpga_passive_serial_loader_assert.svh"
  import fpl_pkg::*;

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  item_t  item;
  logic   in_valid;
  logic   fire;
  logic   emit;
  logic   out_ready;
  burst_t burst;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.byte_count     <= ByteCountRst;
      cfg.high_wait      <= HighWaitRst;
      cfg.low_pulse_wait <= LowPulseWaitRst;
      cfg.rise_wait      <= RiseWaitRst;
      cfg.init_wait      <= InitWaitRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BYTE_COUNT: cfg.byte_count     <= cfg_data;
        REG_HIGH_WAIT:  cfg.high_wait      <= cfg_data[7:0];
        REG_LOW_WAIT:   cfg.low_pulse_wait <= cfg_data[7:0];
        REG_RISE_WAIT:  cfg.rise_wait      <= cfg_data[7:0];
        REG_INIT_WAIT:  cfg.init_wait      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register; an item leaves once the output stage can take its results, or at once if it has none
  assign fire     = in_valid && (!emit || out_ready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.cmd       <= cmd_t'(s_tuser);
      item.data_byte <= s_tdata[7:0];
      item.stat_pin  <= s_tdata[8];
      item.done_pin  <= s_tdata[9];
    end
  end

  // sequencer state
  fpl_step u_step (
    .cur   (state),
    .cfg   (cfg),
    .item  (item),
    .nxt   (state_next),
    .emit  (emit),
    .burst (burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_IDLE;
      state.wait_counter <= '0;
      state.bytes_left   <= '0;
      state.pins         <= 3'b000;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // result register and byte serializer
  fpl_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (fire && emit),
    .burst      (burst),
    .load_ready (out_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // data phase always has bytes still owed
  `FPL_ASSERT_ALWAYS(a_data_count, (state.phase != PH_DATA) || (state.bytes_left != '0), "data phase with zero bytes left")
  // beats inside a byte keep the config pin high
  `FPL_ASSERT_ALWAYS(a_mid_config, !(m_tvalid && !m_tlast) || m_tdata[0], "config pin low inside a byte")
  // a byte burst keeps going until its last beat
  `FPL_ASSERT_NEXT(a_burst_cont, m_tvalid && m_tready && !m_tlast, m_tvalid, "byte burst broken off")
  // an item held in the input register never gets lost to a full output stage
  `FPL_ASSERT_NEXT(a_item_held, in_valid && !fire, in_valid && $stable(item), "pending item dropped")

endmodule

// File: src/fpl_step.sv
module fpl_step (
  input  fpl_pkg::state_t cur,
  input  fpl_pkg::cfg_t   cfg,
  input  fpl_pkg::item_t  item,
  output fpl_pkg::state_t nxt,
  output logic            emit,
  output fpl_pkg::burst_t burst
);
  import fpl_pkg::*;

  logic [WaitW-1:0]  wc_dec;
  logic [CountW-1:0] bl_dec;

  assign wc_dec = (cur.wait_counter != '0) ? cur.wait_counter - 8'd1 : '0;
  assign bl_dec = cur.bytes_left - 21'd1;

  always_comb begin
    nxt            = cur;
    emit           = 1'b0;
    burst.multi    = 1'b0;
    burst.byte_val = item.data_byte;
    burst.pins     = cur.pins;
    burst.status   = ST_BUSY;
    unique case (item.cmd)
      CMD_START: begin
        nxt.pins         = PinConfig;
        nxt.phase        = PH_HIGH;
        nxt.wait_counter = cfg.high_wait;
        emit             = 1'b1;
        burst.pins       = PinConfig;
      end
      CMD_BAD: begin
        emit         = 1'b1;
        burst.status = ST_REJECT;
      end
      CMD_DATA: begin
        emit = 1'b1;
        if (cur.phase != PH_DATA) begin
          burst.status = ST_REJECT;
        end else begin
          burst.multi    = 1'b1;
          nxt.pins       = PinConfig | PinClock | (item.data_byte[7] ? PinData : 3'b000);
          nxt.bytes_left = bl_dec;
          if (bl_dec[7:0] == 8'd0 && !item.stat_pin) begin
            burst.status = ST_LOAD_ERR;
            nxt.phase    = PH_IDLE;
          end else if (bl_dec == '0) begin
            nxt.phase        = PH_INIT;
            nxt.wait_counter = cfg.init_wait;
          end
        end
      end
      default: begin
        // tick
        if (cur.phase == PH_HIGH || cur.phase == PH_LOW || cur.phase == PH_RISE ||
            cur.phase == PH_INIT) begin
          emit             = 1'b1;
          nxt.wait_counter = wc_dec;
          if (wc_dec == '0) begin
            case (cur.phase)
              PH_HIGH: begin
                nxt.pins         = 3'b000;
                nxt.phase        = PH_LOW;
                nxt.wait_counter = cfg.low_pulse_wait;
              end
              PH_LOW: begin
                if (item.stat_pin) begin
                  burst.status = ST_CONF_ERR;
                  nxt.phase    = PH_IDLE;
                end else begin
                  nxt.pins         = PinConfig;
                  nxt.phase        = PH_RISE;
                  nxt.wait_counter = cfg.rise_wait;
                end
              end
              PH_RISE: begin
                if (!item.stat_pin) begin
                  burst.status = ST_CONF_ERR;
                  nxt.phase    = PH_IDLE;
                end else if (cfg.byte_count == '0) begin
                  nxt.phase        = PH_INIT;
                  nxt.wait_counter = cfg.init_wait;
                end else begin
                  nxt.phase      = PH_DATA;
                  nxt.bytes_left = cfg.byte_count;
                end
              end
              default: begin
                burst.status = item.done_pin ? ST_OK : ST_INIT_ERR;
                nxt.phase    = PH_IDLE;
              end
            endcase
          end
          burst.pins = nxt.pins;
        end
      end
    endcase
  end

endmodule

// File: src/fpl_out.sv
module fpl_out (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  fpl_pkg::burst_t burst,
  output logic            load_ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,
  output logic            m_tlast
);
  import fpl_pkg::*;

  logic       busy;
  logic [3:0] beat;
  burst_t     desc;
  logic [2:0] pins_now;
  status_t    status_now;

  assign m_tvalid   = busy;
  assign m_tlast    = desc.multi ? (beat == 4'hf) : 1'b1;
  assign load_ready = !busy || (m_tlast && m_tready);

  // byte beats: even beat clock low, odd beat clock high, data bit beat/2
  assign pins_now   = desc.multi ? {1'b1, beat[0], desc.byte_val[beat[3:1]]} : desc.pins;
  assign status_now = (desc.multi && !m_tlast) ? ST_BUSY : desc.status;
  assign m_tdata    = {2'b00, status_now, pins_now[0], pins_now[1], pins_now[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (load) begin
      busy <= 1'b1;
      beat <= '0;
    end else if (busy && m_tready) begin
      if (m_tlast) begin
        busy <= 1'b0;
      end else begin
        beat <= beat + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= burst;
    end
  end

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpl_pkg::*;

  // run limits
  localparam int unsigned CycleLimit   = 1000000;
  localparam int unsigned SettleCycles = 8;    // covers input reg + output reg + margin
  localparam int unsigned LongHold     = 400;  // receiver hold-off for the backpressure test

  // one pin update as seen on the master side
  typedef struct packed {
    logic    config_pin;
    logic    clock_pin;
    logic    data_pin;
    status_t status;
    logic    last_of_run;
  } pin_update_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // data_byte[7:0], stat_pin, done_pin, zero fill
  logic [1:0]  s_tuser;   // cmd
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // config_pin, clock_pin, data_pin, status_code[2:0], zero fill
  logic        m_tlast;   // last_of_run
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [20:0] cfg_data;

  // shadow copy of the loader: registers, sequencer state, pin latch
  cfg_t        shadow_regs;
  phase_t      seq_phase;
  logic [7:0]  tick_count;
  logic [20:0] bytes_to_go;
  logic [2:0]  pin_latch;

  // pin updates still owed by the loader, oldest first
  pin_update_t pin_updates_due[$];
  int unsigned updates_predicted;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // idling controls
  bit gaps_on;
  bit stalls_on;
  bit hold_req;
  bit hold_done = 1'b0;

  fpga_passive_serial_loader uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // loader prediction
  // ---------------------------------------------------------------------------

  function automatic void owe_update(status_t st, logic last_of_run);
    pin_update_t u;
    u.config_pin  = pin_latch[2];
    u.clock_pin   = pin_latch[1];
    u.data_pin    = pin_latch[0];
    u.status      = st;
    u.last_of_run = last_of_run;
    pin_updates_due.push_back(u);
    updates_predicted++;
  endfunction

  function automatic void clear_loader();
    shadow_regs.byte_count     = ByteCountRst;
    shadow_regs.high_wait      = HighWaitRst;
    shadow_regs.low_pulse_wait = LowPulseWaitRst;
    shadow_regs.rise_wait      = RiseWaitRst;
    shadow_regs.init_wait      = InitWaitRst;
    seq_phase   = PH_IDLE;
    tick_count  = '0;
    bytes_to_go = '0;
    pin_latch   = '0;
  endfunction

  // what one accepted command does to the pins and the sequencer
  function automatic void advance_loader(item_t it);
    status_t st;
    st = ST_BUSY;
    case (it.cmd)
      CMD_START: begin
        // a start always wins, even mid-load
        pin_latch  = PinConfig;
        seq_phase  = PH_HIGH;
        tick_count = shadow_regs.high_wait;
        owe_update(ST_BUSY, 1'b1);
      end
      CMD_BAD: owe_update(ST_REJECT, 1'b1);
      CMD_DATA: begin
        if (seq_phase != PH_DATA) begin
          owe_update(ST_REJECT, 1'b1);
        end else begin
          // lsb first, clock low then clock high per bit; the last beat carries status
          for (int k = 0; k < 8; k++) begin
            pin_latch = PinConfig | (it.data_byte[k] ? PinData : 3'b000);
            owe_update(ST_BUSY, 1'b0);
            pin_latch = pin_latch | PinClock;
            if (k < 7) owe_update(ST_BUSY, 1'b0);
          end
          bytes_to_go = bytes_to_go - 1'b1;
          if (bytes_to_go[7:0] == 8'd0 && !it.stat_pin) begin
            st        = ST_LOAD_ERR;
            seq_phase = PH_IDLE;
          end else if (bytes_to_go == '0) begin
            seq_phase  = PH_INIT;
            tick_count = shadow_regs.init_wait;
          end
          owe_update(st, 1'b1);
        end
      end
      default: begin
        // tick: nothing to time while idle or shifting
        if (seq_phase == PH_IDLE || seq_phase == PH_DATA) return;
        if (tick_count != 0) tick_count = tick_count - 1'b1;
        if (tick_count != 0) begin
          owe_update(ST_BUSY, 1'b1);
          return;
        end
        case (seq_phase)
          PH_HIGH: begin
            pin_latch  = '0;
            seq_phase  = PH_LOW;
            tick_count = shadow_regs.low_pulse_wait;
          end
          PH_LOW: begin
            if (it.stat_pin) begin
              st        = ST_CONF_ERR;
              seq_phase = PH_IDLE;
            end else begin
              pin_latch  = PinConfig;
              seq_phase  = PH_RISE;
              tick_count = shadow_regs.rise_wait;
            end
          end
          PH_RISE: begin
            if (!it.stat_pin) begin
              st        = ST_CONF_ERR;
              seq_phase = PH_IDLE;
            end else if (shadow_regs.byte_count == '0) begin
              // status already high, so the end check passes at once
              seq_phase  = PH_INIT;
              tick_count = shadow_regs.init_wait;
            end else begin
              seq_phase   = PH_DATA;
              bytes_to_go = shadow_regs.byte_count;
            end
          end
          default: begin
            st        = it.done_pin ? ST_OK : ST_INIT_ERR;
            seq_phase = PH_IDLE;
          end
        endcase
        owe_update(st, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // next command of a well-formed load, random where it does not matter
  function automatic item_t next_good_item();
    item_t it;
    it.data_byte = 8'($urandom);
    it.stat_pin  = 1'($urandom);
    it.done_pin  = 1'($urandom);
    case (seq_phase)
      PH_IDLE: it.cmd = CMD_START;
      PH_DATA: begin
        it.cmd = CMD_DATA;
        // periodic status check comes with this byte
        if (bytes_to_go[7:0] == 8'd1) it.stat_pin = 1'b1;
      end
      default: begin
        it.cmd = CMD_TICK;
        if (tick_count <= 8'd1) begin
          it.stat_pin = (seq_phase != PH_LOW);
          it.done_pin = 1'b1;
        end
      end
    endcase
    return it;
  endfunction

  // mostly good loads, with broken checks, stray commands and aborts mixed in
  function automatic item_t next_random_item();
    item_t       it;
    int unsigned roll;
    it   = next_good_item();
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      it.stat_pin = ~it.stat_pin;
      it.done_pin = ~it.done_pin;
    end else if (roll < 9) begin
      it.cmd = cmd_t'($urandom_range(0, 3));
    end else if (roll < 11) begin
      it.cmd = CMD_START;
    end
    return it;
  endfunction

  function automatic logic [20:0] pick_wait();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 21'($urandom_range(0, 3));
    if (roll < 95) return 21'($urandom_range(4, 12));
    return 21'($urandom_range(200, 255));
  endfunction

  // one command transfer on the slave side; valid stays up for a follow-on item
  task automatic send_item(item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, it.done_pin, it.stat_pin, it.data_byte};
    s_tuser  <= it.cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_loader(it);
  endtask

  task automatic send_fields(cmd_t c, logic [7:0] b, logic stat_pin, logic done_pin);
    item_t it;
    it.cmd       = c;
    it.data_byte = b;
    it.stat_pin  = stat_pin;
    it.done_pin  = done_pin;
    send_item(it);
  endtask

  // stop sending, let every owed update drain, then wait out SettleCycles
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pin_updates_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [20:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BYTE_COUNT: shadow_regs.byte_count     = value;
      REG_HIGH_WAIT:  shadow_regs.high_wait      = value[7:0];
      REG_LOW_WAIT:   shadow_regs.low_pulse_wait = value[7:0];
      REG_RISE_WAIT:  shadow_regs.rise_wait      = value[7:0];
      default:        shadow_regs.init_wait      = value[7:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_waits(logic [20:0] hw, logic [20:0] lw, logic [20:0] rw,
                             logic [20:0] iw);
    write_reg(REG_HIGH_WAIT, hw);
    write_reg(REG_LOW_WAIT, lw);
    write_reg(REG_RISE_WAIT, rw);
    write_reg(REG_INIT_WAIT, iw);
  endtask

  task automatic pick_random_settings();
    int unsigned roll;
    logic [20:0] count;
    roll = $urandom_range(0, 99);
    if (roll < 50)      count = 21'($urandom_range(0, 3));
    else if (roll < 80) count = 21'($urandom_range(4, 12));
    // lands on a periodic status check within the first three bytes
    else                count = 21'($urandom_range(1, 4095) * 256 + $urandom_range(1, 3));
    write_reg(REG_BYTE_COUNT, count);
    write_waits(pick_wait(), pick_wait(), pick_wait(), pick_wait());
  endtask

  // good load from where the sequencer stands until it is idle again
  task automatic finish_load();
    send_item(next_good_item());
    while (seq_phase != PH_IDLE) send_item(next_good_item());
  endtask

  task automatic run_random_loads(int unsigned sessions, int unsigned quota);
    int unsigned counted;
    int unsigned seen;
    for (int unsigned s = 0; s < sessions; s++) begin
      settle();
      pick_random_settings();
      counted = 0;
      while (counted < quota) begin
        seen = updates_predicted;
        send_item(next_random_item());
        // ignored ticks do not count
        if (updates_predicted != seen) counted++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register defaults after reset: zero byte count, waits 50/60/30/40
  task automatic test_reset_defaults();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    finish_load();
    settle();
  endtask

  task automatic test_special_cases();
    write_reg(REG_BYTE_COUNT, 21'd2);
    write_waits(21'd0, 21'd0, 21'd0, 21'd0);
    // stray commands while idle
    send_fields(CMD_BAD, 8'hFF, 1'b1, 1'b1);
    send_fields(CMD_DATA, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'hFF, 1'b1, 1'b1);
    // zero waits end on the first tick
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b1, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b1, 1'b0);
    // tick while shifting gives nothing
    send_fields(CMD_TICK, 8'h00, 1'b1, 1'b1);
    send_fields(CMD_DATA, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_DATA, 8'hFF, 1'b1, 1'b1);
    // init done low at the end
    send_fields(CMD_TICK, 8'hFF, 1'b1, 1'b0);
    // status stuck high during the low pulse
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b1, 1'b0);
    // status stays low after config rises
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b0, 1'b0);
    // status low at the end of the data: load error
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_TICK, 8'h00, 1'b1, 1'b0);
    send_fields(CMD_DATA, 8'h5A, 1'b0, 1'b0);
    send_fields(CMD_DATA, 8'hA5, 1'b0, 1'b0);
    // restart while a load is under way
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    send_fields(CMD_START, 8'hFF, 1'b1, 1'b1);
    finish_load();
    settle();
  endtask

  // zero byte count goes straight from the rise check to the init wait
  task automatic test_zero_count();
    write_reg(REG_BYTE_COUNT, 21'd0);
    write_waits(21'd1, 21'd2, 21'd1, 21'd2);
    finish_load();
    settle();
  endtask

  // status checked whenever the remaining count hits a multiple of 256
  task automatic test_periodic_check();
    write_reg(REG_BYTE_COUNT, 21'd257);
    write_waits(21'd1, 21'd1, 21'd1, 21'd1);
    repeat (4) send_item(next_good_item());
    send_fields(CMD_DATA, 8'h81, 1'b1, 1'b0);  // 256 left, status high: keeps going
    send_fields(CMD_DATA, 8'h7E, 1'b0, 1'b1);  // 255 left, status ignored
    settle();
    write_reg(REG_BYTE_COUNT, 21'd258);
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    repeat (3) send_item(next_good_item());
    send_fields(CMD_DATA, 8'h33, 1'b0, 1'b0);
    send_fields(CMD_DATA, 8'hCC, 1'b0, 1'b0);  // 256 left, status low: load error
    settle();
    // count of 2^20 (top bit of the 21-bit register), abandoned after five bytes
    write_reg(REG_BYTE_COUNT, 21'd1048576);
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    repeat (3) send_item(next_good_item());
    repeat (5) send_item(next_good_item());
    send_fields(CMD_START, 8'h00, 1'b0, 1'b0);
    settle();
  endtask

  // receiver holds off while data bytes keep coming; input must stall
  task automatic test_backpressure();
    write_reg(REG_BYTE_COUNT, 21'd40);
    write_waits(21'd0, 21'd0, 21'd0, 21'd0);
    repeat (4) send_item(next_good_item());
    hold_req = 1'b1;
    repeat (40) send_item(next_good_item());
    send_item(next_good_item());
    settle();
  endtask

  task automatic test_random_loads();
    run_random_loads(3, 50);
  endtask

  // no idling on either side at the tail of the run
  task automatic test_quiet_tail();
    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_random_loads(1, 40);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall bursts and the long hold-off
  // ---------------------------------------------------------------------------

  initial begin : ready_gen
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_done = 1'b1;
        m_tready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result compare: every master transfer against the oldest owed update
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_compare
    pin_update_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pin_updates_due.size() == 0) begin
        $error("pin update with nothing owed: m_tdata %h m_tlast %b", m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pin_updates_due.pop_front();
        if (m_tdata[0] !== want.config_pin) begin
          $error("config_pin expected %0d actual %0d", want.config_pin, m_tdata[0]);
          mismatches++;
        end
        if (m_tdata[1] !== want.clock_pin) begin
          $error("clock_pin expected %0d actual %0d", want.clock_pin, m_tdata[1]);
          mismatches++;
        end
        if (m_tdata[2] !== want.data_pin) begin
          $error("data_pin expected %0d actual %0d", want.data_pin, m_tdata[2]);
          mismatches++;
        end
        if (m_tdata[5:3] !== want.status) begin
          $error("status_code expected %0d actual %0d", want.status, m_tdata[5:3]);
          mismatches++;
        end
        if (m_tlast !== want.last_of_run) begin
          $error("last_of_run expected %0d actual %0d", want.last_of_run, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= CMD_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= REG_BYTE_COUNT;
    cfg_data  <= '0;
    updates_predicted = 0;
    gaps_on           = 1'b0;
    stalls_on         = 1'b0;
    hold_req          = 1'b0;
    clear_loader();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_special_cases();
    test_zero_count();
    test_periodic_check();
    test_backpressure();
    test_random_loads();
    test_quiet_tail();

    // final drain, then a short tail for stray transfers
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
